// ===== src/assert_macros.svh =====
// Assertion macros shared by the address decoder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed in address decoder");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed in address decoder");

`endif

// ===== src/iord_pkg.sv =====
// Package for the I/O region address decoder: field widths, request and
// status codes, and the request/response structs. Depends on nothing.
`timescale 1ns / 1ps

package iord_pkg;

    localparam int ADDR_W   = 32;
    localparam int DATA_W   = 32;
    localparam int PAGES_W  = 21;
    localparam int SIZE_W   = 2;
    localparam int REQ_W    = 2;
    localparam int RNUM_W   = 4;
    localparam int STATUS_W = 3;

    localparam int MAX_REGIONS_DEF = 16;
    localparam int PAGE_SHIFT_DEF  = 12;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } req_kind_t;

    typedef enum logic [SIZE_W-1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_HALF = 2'd1,
        SIZE_WORD = 2'd2
    } size_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_MISALIGNED = 3'd1,
        ST_UNMAPPED   = 3'd2,
        ST_OVERLAP    = 3'd3,
        ST_FULL       = 3'd4,
        ST_BAD_REGION = 3'd5
    } status_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [ADDR_W-1:0]  address;
        logic [SIZE_W-1:0]  access_size;
        logic [DATA_W-1:0]  write_data;
        logic [PAGES_W-1:0] region_pages;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [RNUM_W-1:0]  region_number;
        logic [ADDR_W-1:0]  region_offset;
        logic               is_write;
        logic [SIZE_W-1:0]  out_size;
        logic [DATA_W-1:0]  out_data;
    } rsp_t;

endpackage

// ===== src/iord_table.sv =====
// Region table of the I/O region address decoder: stored ranges, add checks
// and access lookup. Depends on iord_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iord_table #(
    parameter int MAX_REGIONS = iord_pkg::MAX_REGIONS_DEF,
    parameter int PAGE_SHIFT  = iord_pkg::PAGE_SHIFT_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  iord_pkg::req_t req,
    input  logic           req_take,
    output iord_pkg::rsp_t rsp
);

    localparam int PN_W  = iord_pkg::ADDR_W - PAGE_SHIFT;
    localparam int SUM_W = ((PN_W > iord_pkg::PAGES_W) ? PN_W : iord_pkg::PAGES_W) + 1;
    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam logic [SUM_W-1:0] PAGE_SPACE = SUM_W'(1) << PN_W;

    logic [PN_W-1:0]              base_reg  [MAX_REGIONS];
    logic [iord_pkg::PAGES_W-1:0] count_reg [MAX_REGIONS];
    logic [MAX_REGIONS-1:0]       used_reg;
    logic [MAX_REGIONS-1:0]       used_next;
    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             cnt_next;

    logic [SUM_W-1:0]       first_page;
    logic [SUM_W-1:0]       last_excl;
    logic [MAX_REGIONS-1:0] hit;
    logic [MAX_REGIONS-1:0] overlap;
    logic [IDX_W-1:0]       hit_idx;
    logic [PN_W-1:0]        hit_base;
    logic                   bad_region;
    logic                   table_full;
    logic                   misaligned;
    logic                   add_ok;
    logic                   commit;
    logic [IDX_W-1:0]       wr_idx;

    assign first_page = SUM_W'(req.address[iord_pkg::ADDR_W-1:PAGE_SHIFT]);
    assign last_excl  = first_page + SUM_W'(req.region_pages);
    assign bad_region = (req.address[PAGE_SHIFT-1:0] != '0) || (last_excl > PAGE_SPACE);
    assign table_full = cnt_reg >= CNT_W'(MAX_REGIONS);
    assign wr_idx     = cnt_reg[IDX_W-1:0];

    // Regions never overlap, so at most one entry can hit an access page.
    always_comb begin
        for (int i = 0; i < MAX_REGIONS; i++) begin
            hit[i] = used_reg[i]
                && (first_page >= SUM_W'(base_reg[i]))
                && (first_page < SUM_W'(base_reg[i]) + SUM_W'(count_reg[i]));
            overlap[i] = used_reg[i] && (count_reg[i] != '0)
                && (first_page < SUM_W'(base_reg[i]) + SUM_W'(count_reg[i]))
                && (SUM_W'(base_reg[i]) < last_excl);
        end
    end

    always_comb begin
        hit_idx  = '0;
        hit_base = '0;
        for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_idx  = IDX_W'(i);
                hit_base = base_reg[i];
            end
        end
    end

    always_comb begin
        case (req.access_size)
            iord_pkg::SIZE_BYTE: misaligned = 1'b0;
            iord_pkg::SIZE_HALF: misaligned = req.address[0];
            iord_pkg::SIZE_WORD: misaligned = |req.address[1:0];
            default:             misaligned = 1'b1;
        endcase
    end

    always_comb begin
        rsp    = '0;
        add_ok = 1'b0;
        case (req.req_type)
            iord_pkg::REQ_ADD: begin
                if (bad_region) begin
                    rsp.status = iord_pkg::ST_BAD_REGION;
                end else if (table_full) begin
                    rsp.status = iord_pkg::ST_FULL;
                end else if ((req.region_pages != '0) && (|overlap)) begin
                    rsp.status = iord_pkg::ST_OVERLAP;
                end else begin
                    rsp.status        = iord_pkg::ST_OK;
                    rsp.region_number = iord_pkg::RNUM_W'(cnt_reg);
                    add_ok            = 1'b1;
                end
            end
            iord_pkg::REQ_READ, iord_pkg::REQ_WRITE: begin
                rsp.is_write = (req.req_type == iord_pkg::REQ_WRITE);
                rsp.out_size = req.access_size;
                if (misaligned) begin
                    rsp.status = iord_pkg::ST_MISALIGNED;
                end else if (|hit) begin
                    rsp.status        = iord_pkg::ST_OK;
                    rsp.region_number = iord_pkg::RNUM_W'(hit_idx);
                    rsp.region_offset = req.address
                        - (iord_pkg::ADDR_W'(hit_base) << PAGE_SHIFT);
                    rsp.out_data      = rsp.is_write ? req.write_data : '0;
                end else begin
                    rsp.status = iord_pkg::ST_UNMAPPED;
                end
            end
            default: begin
                rsp = '0;
            end
        endcase
    end

    // The table changes only when a successful add leaves the input stage.
    assign commit = req_take && add_ok;

    always_comb begin
        used_next = used_reg;
        cnt_next  = cnt_reg;
        if (commit) begin
            used_next[wr_idx] = 1'b1;
            cnt_next          = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            used_reg <= used_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            base_reg[wr_idx]  <= req.address[iord_pkg::ADDR_W-1:PAGE_SHIFT];
            count_reg[wr_idx] <= req.region_pages;
        end
    end

    `ASSERT_IMPLY(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(MAX_REGIONS))
    `ASSERT_NEXT(a_cnt_step, aclk, aresetn, commit, cnt_reg == $past(cnt_reg) + CNT_W'(1))
    `ASSERT_IMPLY(a_hit_unique, aclk, aresetn, 1'b1, $onehot0(hit))

endmodule

// ===== src/io_region_address_decoder.sv =====
// Top level of the I/O region address decoder: input and result registers
// around the region table. Depends on iord_pkg, iord_table, assert_macros.svh.
//
// Usage:
//   Requests enter on the s_ channel (valid/ready): an add installs a region of
//   s_region_pages pages at page-aligned base s_address and is answered with
//   the assigned region number; a read or write is checked for natural
//   alignment and looked up, and is answered with region number, offset from
//   the region base, direction, size and, for writes, the write data.
//   Results leave on the m_ channel (valid/ready), one per request, in order.
//   Request type three is accepted and dropped without a result.
//   Each request passes through the input register, then the result register,
//   before its result appears on the m_ channel. Throughput: one request per
//   cycle while m_ready stays high; the table lookup and add checks sit in one
//   combinational pass between the two registers, and an add updates the table
//   as it leaves the input register, so the next request already sees it.
//   Reset (aresetn low, synchronous) empties the region table and both
//   registers. When the receiver stalls, the result register holds, one more
//   request is taken into the input register, and then s_ready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module io_region_address_decoder #(
    parameter int MAX_REGIONS = iord_pkg::MAX_REGIONS_DEF,
    parameter int PAGE_SHIFT  = iord_pkg::PAGE_SHIFT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [iord_pkg::REQ_W-1:0]      s_req_type,
    input  logic [iord_pkg::ADDR_W-1:0]     s_address,
    input  logic [iord_pkg::SIZE_W-1:0]     s_access_size,
    input  logic [iord_pkg::DATA_W-1:0]     s_write_data,
    input  logic [iord_pkg::PAGES_W-1:0]    s_region_pages,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [iord_pkg::STATUS_W-1:0]   m_status,
    output logic [iord_pkg::RNUM_W-1:0]     m_region_number,
    output logic [iord_pkg::ADDR_W-1:0]     m_region_offset,
    output logic                            m_is_write,
    output logic [iord_pkg::SIZE_W-1:0]     m_out_size,
    output logic [iord_pkg::DATA_W-1:0]     m_out_data
);

    logic           in_valid_reg;
    logic           in_valid_next;
    iord_pkg::req_t in_req_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    iord_pkg::rsp_t out_rsp_reg;
    iord_pkg::rsp_t rsp;
    logic           s_fire;
    logic           advance;
    logic           req_known;
    logic           fail_clean;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_fire    = s_valid && s_ready;
    assign req_known = s_req_type inside {iord_pkg::REQ_ADD, iord_pkg::REQ_READ,
                                          iord_pkg::REQ_WRITE};

    iord_table #(
        .MAX_REGIONS (MAX_REGIONS),
        .PAGE_SHIFT  (PAGE_SHIFT)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (in_req_reg),
        .req_take (advance),
        .rsp      (rsp)
    );

    // An unused request type is taken off the channel but never occupies the stage.
    always_comb begin
        if (s_fire) begin
            in_valid_next = req_known;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb begin
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_req_reg.req_type     <= s_req_type;
            in_req_reg.address      <= s_address;
            in_req_reg.access_size  <= s_access_size;
            in_req_reg.write_data   <= s_write_data;
            in_req_reg.region_pages <= s_region_pages;
        end
        if (advance) begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_rsp_reg.status;
    assign m_region_number = out_rsp_reg.region_number;
    assign m_region_offset = out_rsp_reg.region_offset;
    assign m_is_write      = out_rsp_reg.is_write;
    assign m_out_size      = out_rsp_reg.out_size;
    assign m_out_data      = out_rsp_reg.out_data;

    assign fail_clean = (m_region_offset == '0) && (m_out_data == '0)
                     && (m_region_number == '0);

    `ASSERT_IMPLY(a_ready_low, aclk, aresetn, !s_ready, in_valid_reg && out_valid_reg && !m_ready)
    `ASSERT_NEXT(a_advance_fills, aclk, aresetn, advance, m_valid)
    `ASSERT_IMPLY(a_fail_zero, aclk, aresetn, m_valid && (m_status != iord_pkg::ST_OK), fail_clean)

endmodule
